### src/gtbp_pkg.sv
// Package for the gshare / tournament branch predictor.
// Holds default sizes, mode and command codes and the 2-bit counter helpers.
// No dependencies.
`default_nettype none

package gtbp_pkg;

  // default table sizes
  localparam int GHIST_BITS_DEF    = 12;
  localparam int LHIST_BITS_DEF    = 10;
  localparam int PC_INDEX_BITS_DEF = 10;

  localparam int PC_W   = 32;
  localparam int MODE_W = 2;
  localparam int CTR_W  = 2;

  // predictor modes
  localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GSHARE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOURN  = 2'd2;

  // command codes
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_TRAIN   = 1'b1;

  // counter value after reset: weakly not taken / weakly global
  localparam logic [CTR_W-1:0] CTR_INIT = 2'd1;
  localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN  = 2'd0;

  // saturating step of a 2-bit counter
  function automatic logic [CTR_W-1:0] ctr_bump(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

  // counter above 1 means taken (or local, for a chooser)
  function automatic logic ctr_taken(input logic [CTR_W-1:0] c);
    return c[CTR_W-1];
  endfunction

endpackage

`default_nettype wire

### src/gtbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module gtbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/gtbp_table.sv
// Read-modify-write table: RAM plus a one-deep bypass of the write made at the
// edge where the current entry was read, and a clear write path. Uses gtbp_ram.
`default_nettype none

module gtbp_table #(
  parameter int                IDX_BITS = 12,
  parameter int                WIDTH    = 2,
  parameter logic [WIDTH-1:0]  INIT     = '0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                clr_en,
  input  wire logic [IDX_BITS-1:0] clr_addr,
  input  wire logic [IDX_BITS-1:0] rd_addr,   // read issued every cycle
  input  wire logic [IDX_BITS-1:0] cur_addr,  // entry read in the previous cycle
  output logic      [WIDTH-1:0]    cur_data,
  input  wire logic                wr_en,
  input  wire logic [WIDTH-1:0]    wr_data
);

  logic                we;
  logic [IDX_BITS-1:0] waddr;
  logic [WIDTH-1:0]    wdata;
  logic [WIDTH-1:0]    rdata;
  logic                fwd_valid;
  logic [IDX_BITS-1:0] fwd_addr;
  logic [WIDTH-1:0]    fwd_data;

  assign we    = clr_en | wr_en;
  assign waddr = clr_en ? clr_addr : cur_addr;
  assign wdata = clr_en ? INIT : wr_data;

  gtbp_ram #(
    .WIDTH (WIDTH),
    .DEPTH (1 << IDX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // RAM returns old data when read and write collide; keep the new word here
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
    fwd_addr <= cur_addr;
    fwd_data <= wr_data;
  end

  assign cur_data = (fwd_valid && fwd_addr == cur_addr) ? fwd_data : rdata;

endmodule

`default_nettype wire

### src/gtbp_clear.sv
// Clearing sequencer: after reset sweeps every table address once.
// Depends on nothing.
`default_nettype none

module gtbp_clear #(
  parameter int ADDR_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  output logic                      active,
  output logic      [ADDR_BITS-1:0] addr
);

  typedef enum logic [1:0] {
    CLR_RUN  = 2'b01,
    CLR_DONE = 2'b10
  } clr_state_t;

  clr_state_t state;
  clr_state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      CLR_RUN: begin
        if (addr == '1) begin
          state_next = CLR_DONE;
        end
      end
      CLR_DONE: state_next = CLR_DONE;
      default:  state_next = CLR_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR_RUN;
      addr  <= '0;
    end else begin
      state <= state_next;
      if (state == CLR_RUN) begin
        addr <= addr + 1'b1;
      end
    end
  end

  assign active = (state == CLR_RUN);

endmodule

`default_nettype wire

### src/gshare_tournament_branch_predictor_top.sv
// Gshare / tournament branch predictor, top level.
// Depends on gtbp_pkg, gtbp_clear, gtbp_table (and through it gtbp_ram).
//
// Use:
//   Commands enter on start/cmd/pc/outcome and are taken at a clock edge with
//   start high and busy low. A predict command (cmd 0) yields one word on
//   taken, marked by done for exactly one cycle; a train command (cmd 1)
//   yields nothing. The result must be taken when shown: there is no hold.
//   The mode register is written through mode_valid/mode_ready/mode; ready is
//   always high. Write it only while no command is in flight.
// Timing:
//   One command per cycle while busy is low. done and taken come from the result
//   register, behind stage 1 and stage 2. The depth comes from two dependent RAM
//   reads: the local history table read by pc, then the counter tables read with
//   that history (or with the global history), each with a registered read
//   port and a one-deep bypass for the entry written in the same cycle.
// Reset:
//   rst clears the pipeline and mode (static). A clearing pass then writes
//   every table entry, one address per cycle, over 2^max(GHIST_BITS,
//   LHIST_BITS, PC_INDEX_BITS) addresses (4096 at default sizes); busy is high
//   during the pass. Mode writes are taken during the pass.
`default_nettype none

module gshare_tournament_branch_predictor_top
  import gtbp_pkg::*;
#(
  parameter int GHIST_BITS    = GHIST_BITS_DEF,
  parameter int LHIST_BITS    = LHIST_BITS_DEF,
  parameter int PC_INDEX_BITS = PC_INDEX_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd,
  input  wire logic [PC_W-1:0]   pc,
  input  wire logic              outcome,
  output logic                   done,
  output logic                   taken,
  input  wire logic              mode_valid,
  output logic                   mode_ready,
  input  wire logic [MODE_W-1:0] mode
);

  localparam int MAX_GL   = (GHIST_BITS > LHIST_BITS) ? GHIST_BITS : LHIST_BITS;
  localparam int CLR_BITS = (MAX_GL > PC_INDEX_BITS) ? MAX_GL : PC_INDEX_BITS;

  // config
  logic [MODE_W-1:0] cur_mode;

  // clearing pass
  logic                clr_active;
  logic [CLR_BITS-1:0] clr_addr;
  logic                clr_g;
  logic                clr_l;
  logic                clr_p;

  // accept stage and global histories
  logic                  accept;
  logic [GHIST_BITS-1:0] ghist;
  logic [GHIST_BITS-1:0] thist;
  logic [GHIST_BITS:0]   ghist_shift;
  logic [GHIST_BITS:0]   thist_shift;

  // stage 1: local history available
  logic                     s1_valid;
  logic                     s1_cmd;
  logic [MODE_W-1:0]        s1_mode;
  logic                     s1_outcome;
  logic [PC_INDEX_BITS-1:0] s1_pidx;
  logic [GHIST_BITS-1:0]    s1_gidx;
  logic [GHIST_BITS-1:0]    s1_th;
  logic [LHIST_BITS-1:0]    s1_lh;
  logic [LHIST_BITS:0]      lh_shift;
  logic                     lht_wr;

  // stage 2: counters available
  logic                  s2_valid;
  logic                  s2_cmd;
  logic [MODE_W-1:0]     s2_mode;
  logic                  s2_outcome;
  logic [GHIST_BITS-1:0] s2_gidx;
  logic [GHIST_BITS-1:0] s2_th;
  logic [LHIST_BITS-1:0] s2_lh;
  logic [CTR_W-1:0]      gs_ctr;
  logic [CTR_W-1:0]      loc_ctr;
  logic [CTR_W-1:0]      glb_ctr;
  logic [CTR_W-1:0]      cho_ctr;
  logic                  lp;
  logic                  gp;
  logic                  pred;
  logic                  s2_train;
  logic                  gs_wr;
  logic                  tn_wr;
  logic                  cho_wr;

  // ---------------- config ----------------
  assign mode_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode <= MODE_STATIC;
    end else if (mode_valid && mode_ready) begin
      cur_mode <= mode;
    end
  end

  // ---------------- clearing ----------------
  gtbp_clear #(
    .ADDR_BITS (CLR_BITS)
  ) u_clear (
    .clk    (clk),
    .rst    (rst),
    .active (clr_active),
    .addr   (clr_addr)
  );

  // smaller tables only take the addresses they have
  assign clr_g = clr_active && ((clr_addr >> GHIST_BITS) == '0);
  assign clr_l = clr_active && ((clr_addr >> LHIST_BITS) == '0);
  assign clr_p = clr_active && ((clr_addr >> PC_INDEX_BITS) == '0);

  assign busy = clr_active;

  // ---------------- accept ----------------
  assign accept      = start && !busy;
  assign ghist_shift = {ghist, outcome};
  assign thist_shift = {thist, outcome};

  // histories depend only on the outcome: advance them at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
      thist <= '0;
    end else if (accept && cmd == CMD_TRAIN) begin
      if (cur_mode == MODE_GSHARE) begin
        ghist <= ghist_shift[GHIST_BITS-1:0];
      end
      if (cur_mode == MODE_TOURN) begin
        thist <= thist_shift[GHIST_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_cmd     <= cmd;
    s1_mode    <= cur_mode;
    s1_outcome <= outcome;
    s1_pidx    <= pc[PC_INDEX_BITS-1:0];
    s1_gidx    <= pc[GHIST_BITS-1:0] ^ ghist;
    s1_th      <= thist;
  end

  // ---------------- stage 1: local history table ----------------
  assign lh_shift = {s1_lh, s1_outcome};
  assign lht_wr   = s1_valid && s1_cmd == CMD_TRAIN && s1_mode == MODE_TOURN;

  gtbp_table #(
    .IDX_BITS (PC_INDEX_BITS),
    .WIDTH    (LHIST_BITS),
    .INIT     ('0)
  ) u_lht (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clr_p),
    .clr_addr (clr_addr[PC_INDEX_BITS-1:0]),
    .rd_addr  (pc[PC_INDEX_BITS-1:0]),
    .cur_addr (s1_pidx),
    .cur_data (s1_lh),
    .wr_en    (lht_wr),
    .wr_data  (lh_shift[LHIST_BITS-1:0])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_cmd     <= s1_cmd;
    s2_mode    <= s1_mode;
    s2_outcome <= s1_outcome;
    s2_gidx    <= s1_gidx;
    s2_th      <= s1_th;
    s2_lh      <= s1_lh;
  end

  // ---------------- stage 2: counters ----------------
  assign s2_train = s2_valid && s2_cmd == CMD_TRAIN;
  assign gs_wr    = s2_train && s2_mode == MODE_GSHARE;
  assign tn_wr    = s2_train && s2_mode == MODE_TOURN;
  assign lp       = ctr_taken(loc_ctr);
  assign gp       = ctr_taken(glb_ctr);
  // chooser moves only when the two sides disagree
  assign cho_wr   = tn_wr && (lp != gp);

  gtbp_table #(
    .IDX_BITS (GHIST_BITS),
    .WIDTH    (CTR_W),
    .INIT     (CTR_INIT)
  ) u_gshare (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clr_g),
    .clr_addr (clr_addr[GHIST_BITS-1:0]),
    .rd_addr  (s1_gidx),
    .cur_addr (s2_gidx),
    .cur_data (gs_ctr),
    .wr_en    (gs_wr),
    .wr_data  (ctr_bump(gs_ctr, s2_outcome))
  );

  gtbp_table #(
    .IDX_BITS (LHIST_BITS),
    .WIDTH    (CTR_W),
    .INIT     (CTR_INIT)
  ) u_local (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clr_l),
    .clr_addr (clr_addr[LHIST_BITS-1:0]),
    .rd_addr  (s1_lh),
    .cur_addr (s2_lh),
    .cur_data (loc_ctr),
    .wr_en    (tn_wr),
    .wr_data  (ctr_bump(loc_ctr, s2_outcome))
  );

  gtbp_table #(
    .IDX_BITS (GHIST_BITS),
    .WIDTH    (CTR_W),
    .INIT     (CTR_INIT)
  ) u_global (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clr_g),
    .clr_addr (clr_addr[GHIST_BITS-1:0]),
    .rd_addr  (s1_th),
    .cur_addr (s2_th),
    .cur_data (glb_ctr),
    .wr_en    (tn_wr),
    .wr_data  (ctr_bump(glb_ctr, s2_outcome))
  );

  gtbp_table #(
    .IDX_BITS (GHIST_BITS),
    .WIDTH    (CTR_W),
    .INIT     (CTR_INIT)
  ) u_chooser (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clr_g),
    .clr_addr (clr_addr[GHIST_BITS-1:0]),
    .rd_addr  (s1_th),
    .cur_addr (s2_th),
    .cur_data (cho_ctr),
    .wr_en    (cho_wr),
    .wr_data  (ctr_bump(cho_ctr, lp == s2_outcome))
  );

  always_comb begin
    case (s2_mode)
      MODE_STATIC: pred = 1'b1;
      MODE_GSHARE: pred = ctr_taken(gs_ctr);
      MODE_TOURN:  pred = ctr_taken(cho_ctr) ? lp : gp;
      default:     pred = 1'b0;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid && s2_cmd == CMD_PREDICT;
    end
    taken <= pred;
  end

  // ---------------- assertions ----------------
  a_done_from_predict: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && cmd == CMD_PREDICT, 3))
    else $error("result word without a matching predict command");

  a_no_done_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result word during clearing pass");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire

### verif/tb_gshare_tournament_branch_predictor_top.sv
`timescale 1ns / 100ps
// Testbench for gshare_tournament_branch_predictor_top: directed table, then random branch streams.
// Depends on gtbp_pkg and the predictor RTL. A table model predicts taken words no row fixes.

module tb_gshare_tournament_branch_predictor_top;
  import gtbp_pkg::*;

  localparam int GB = GHIST_BITS_DEF;
  localparam int LB = LHIST_BITS_DEF;
  localparam int PB = PC_INDEX_BITS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYC = 8;
  localparam int DRAIN_LIMIT = 2000;
  localparam int NBR = 12;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              cmd;
  logic [PC_W-1:0]   pc;
  logic              outcome;
  logic              done;
  logic              taken;
  logic              mode_valid;
  logic              mode_ready;
  logic [MODE_W-1:0] mode;

  gshare_tournament_branch_predictor_top u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .pc         (pc),
    .outcome    (outcome),
    .done       (done),
    .taken      (taken),
    .mode_valid (mode_valid),
    .mode_ready (mode_ready),
    .mode       (mode)
  );

  // table model of the predictor
  logic [MODE_W-1:0] bp_mode;
  logic [GB-1:0]     gs_hist;
  logic [CTR_W-1:0]  gs_ctr [0:(1<<GB)-1];
  logic [LB-1:0]     lh_tab [0:(1<<PB)-1];
  logic [CTR_W-1:0]  loc_ctr [0:(1<<LB)-1];
  logic [GB-1:0]     tn_hist;
  logic [CTR_W-1:0]  gl_ctr [0:(1<<GB)-1];
  logic [CTR_W-1:0]  ch_ctr [0:(1<<GB)-1];

  logic taken_q [$];
  int n_err, n_pred, n_train, n_res, n_cfg;
  int idle_pct;

  // branch pool for the random streams
  logic [PC_W-1:0] br_pc [NBR];
  int br_bias [NBR];
  int br_period [NBR];
  int br_cnt [NBR];

  typedef struct packed {
    logic [MODE_W-1:0] md;
    logic              c;
    logic [PC_W-1:0]   p;
    logic              o;
    logic              chk;
    logic              t;
  } step_row_t;

  step_row_t dir_rows [0:22] = '{
    '{MODE_STATIC, CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b1},
    '{MODE_STATIC, CMD_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1},
    '{MODE_STATIC, CMD_TRAIN,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{MODE_STATIC, CMD_TRAIN,   32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{MODE_STATIC, CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b1},
    '{MODE_GSHARE, CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
    '{MODE_GSHARE, CMD_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0},
    '{MODE_GSHARE, CMD_TRAIN,   32'h0000_0ABC, 1'b1, 1'b0, 1'b0},
    // history aliases this onto the same counter
    '{MODE_GSHARE, CMD_TRAIN,   32'h0000_0ABD, 1'b1, 1'b0, 1'b0},
    '{MODE_GSHARE, CMD_PREDICT, 32'h0000_0ABF, 1'b0, 1'b0, 1'b0},
    '{MODE_GSHARE, CMD_TRAIN,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{MODE_GSHARE, CMD_TRAIN,   32'hFFFF_F000, 1'b0, 1'b0, 1'b0},
    '{MODE_UNUSED, CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
    '{MODE_UNUSED, CMD_TRAIN,   32'h0000_0000, 1'b1, 1'b0, 1'b0},
    '{MODE_UNUSED, CMD_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    // gshare training leaves the tournament tables alone
    '{MODE_TOURN,  CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
    '{MODE_TOURN,  CMD_TRAIN,   32'h0000_03FF, 1'b1, 1'b0, 1'b0},
    '{MODE_TOURN,  CMD_TRAIN,   32'h0000_03FF, 1'b1, 1'b0, 1'b0},
    // local and global disagree here, so the chooser moves
    '{MODE_TOURN,  CMD_TRAIN,   32'hFFFF_FC00, 1'b0, 1'b0, 1'b0},
    '{MODE_TOURN,  CMD_TRAIN,   32'h0000_03FF, 1'b1, 1'b0, 1'b0},
    '{MODE_TOURN,  CMD_PREDICT, 32'h0000_03FF, 1'b0, 1'b0, 1'b0},
    '{MODE_TOURN,  CMD_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{MODE_STATIC, CMD_PREDICT, 32'h1234_5678, 1'b0, 1'b1, 1'b1}
  };

  function automatic logic [CTR_W-1:0] sat_step(input logic [CTR_W-1:0] c, input logic up);
    if (up) begin
      return (c == CTR_MAX) ? CTR_MAX : c + 1'b1;
    end
    return (c == CTR_MIN) ? CTR_MIN : c - 1'b1;
  endfunction

  function automatic logic bp_predict(input logic [PC_W-1:0] p);
    logic [GB-1:0] gi;
    logic [LB-1:0] lh;
    case (bp_mode)
      MODE_STATIC: return 1'b1;
      MODE_GSHARE: begin
        gi = p[GB-1:0] ^ gs_hist;
        return gs_ctr[gi][CTR_W-1];
      end
      MODE_TOURN: begin
        lh = lh_tab[p[PB-1:0]];
        if (ch_ctr[tn_hist][CTR_W-1]) begin
          return loc_ctr[lh][CTR_W-1];
        end
        return gl_ctr[tn_hist][CTR_W-1];
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic bp_train(input logic [PC_W-1:0] p, input logic o);
    logic [GB-1:0] gi;
    logic [GB-1:0] gh;
    logic [LB-1:0] lh;
    logic [PB-1:0] pi;
    logic lp, gp;
    case (bp_mode)
      MODE_GSHARE: begin
        gi = p[GB-1:0] ^ gs_hist;
        gs_ctr[gi] = sat_step(gs_ctr[gi], o);
        gs_hist = {gs_hist[GB-2:0], o};
      end
      MODE_TOURN: begin
        pi = p[PB-1:0];
        lh = lh_tab[pi];
        gh = tn_hist;
        lp = loc_ctr[lh][CTR_W-1];
        gp = gl_ctr[gh][CTR_W-1];
        loc_ctr[lh] = sat_step(loc_ctr[lh], o);
        lh_tab[pi] = {lh[LB-2:0], o};
        gl_ctr[gh] = sat_step(gl_ctr[gh], o);
        tn_hist = {gh[GB-2:0], o};
        // chooser moves toward local only when the two sides disagree
        if (lp != gp) begin
          ch_ctr[gh] = sat_step(ch_ctr[gh], lp == o);
        end
      end
      default: ;
    endcase
  endtask

  // call at a falling edge; returns at the falling edge after the accepting one
  task automatic issue(input logic c, input logic [PC_W-1:0] p, input logic o,
                       input logic chk, input logic t_exp);
    // idle each cycle with the phase's odds
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd = c;
    pc = p;
    outcome = o;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (c == CMD_PREDICT) begin
      taken_q.push_back(chk ? t_exp : bp_predict(p));
      n_pred++;
    end else begin
      bp_train(p, o);
      n_train++;
    end
  endtask

  // drop start, wait out every pending word, then let the pipeline settle
  task automatic drain();
    int k;
    start = 1'b0;
    k = 0;
    while (taken_q.size() != 0 && k < DRAIN_LIMIT) begin
      @(negedge clk);
      k++;
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] v);
    drain();
    mode_valid = 1'b1;
    mode = v;
    do @(posedge clk); while (mode_ready !== 1'b1);
    @(negedge clk);
    mode_valid = 1'b0;
    bp_mode = v;
    n_cfg++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin : result_check
    logic want;
    if (!rst && done === 1'b1) begin
      if (taken_q.size() == 0) begin
        $error("unexpected taken word: taken=%0b", taken);
        n_err++;
      end else begin
        want = taken_q.pop_front();
        n_res++;
        if (taken !== want) begin
          $error("taken mismatch: expected %0b, actual %0b", want, taken);
          n_err++;
        end
      end
    end
  end

  initial begin : stim
    logic [MODE_W-1:0] ph_mode [8];
    int ph_idle [8];
    int b, n;
    logic o;
    ph_mode = '{MODE_GSHARE, MODE_TOURN, MODE_STATIC, MODE_TOURN,
                MODE_GSHARE, MODE_UNUSED, MODE_TOURN, MODE_GSHARE};
    ph_idle = '{0, 54, 36, 0, 54, 36, 54, 0};
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_PREDICT;
    pc = '0;
    outcome = 1'b0;
    mode_valid = 1'b0;
    mode = MODE_STATIC;
    n_err = 0;
    n_pred = 0;
    n_train = 0;
    n_res = 0;
    n_cfg = 0;
    idle_pct = 0;
    bp_mode = MODE_STATIC;
    gs_hist = '0;
    tn_hist = '0;
    for (int i = 0; i < (1 << GB); i++) begin
      gs_ctr[i] = CTR_INIT;
      gl_ctr[i] = CTR_INIT;
      ch_ctr[i] = CTR_INIT;
    end
    for (int i = 0; i < (1 << PB); i++) lh_tab[i] = '0;
    for (int i = 0; i < (1 << LB); i++) loc_ctr[i] = CTR_INIT;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table; first row waits out the clearing pass through busy
    foreach (dir_rows[i]) begin
      if (dir_rows[i].md != bp_mode) write_mode(dir_rows[i].md);
      issue(dir_rows[i].c, dir_rows[i].p, dir_rows[i].o, dir_rows[i].chk, dir_rows[i].t);
    end

    // random phases: mostly predict/train pairs on a small branch pool
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph_mode[ph]);
      idle_pct = ph_idle[ph];
      for (int i = 0; i < NBR; i++) begin
        br_pc[i] = $urandom;
        br_bias[i] = 25 * $urandom_range(0, 4);
        br_period[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 6) : 0;
        br_cnt[i] = 0;
      end
      n = 0;
      while (n < 191) begin
        if ($urandom_range(0, 99) < 80) begin
          b = $urandom_range(0, NBR - 1);
          if (br_period[b] != 0) begin
            o = (br_cnt[b] != br_period[b] - 1);
            br_cnt[b] = (br_cnt[b] + 1) % br_period[b];
          end else begin
            o = ($urandom_range(0, 99) < br_bias[b]);
          end
          issue(CMD_PREDICT, br_pc[b], 1'($urandom_range(0, 1)), 1'b0, 1'b0);
          issue(CMD_TRAIN, br_pc[b], o, 1'b0, 1'b0);
          n += 2;
        end else begin
          issue(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
          n++;
        end
        // hold off now and then until every word is back
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    drain();
    if (taken_q.size() != 0) begin
      $error("taken words never seen: %0d", taken_q.size());
      n_err++;
    end
    $display("Ran %0d predictions and %0d trains over %0d mode writes (all four codes),",
             n_pred, n_train, n_cfg);
    $display("with sender gaps of 0/36/54 percent; %0d taken words checked.", n_res);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
